// File: sv/mktd_pkg.sv
// Shared types, constants and helper functions for the key timing decoder.
package mktd_pkg;

   localparam int BUFFER_SLOTS = 31;
   localparam int CNT_BITS     = 16;
   localparam int CFG_W        = 16;
   localparam int LEN_W        = 5;
   localparam int LEN_MAX      = (1 << LEN_W) - 1;
   localparam int SLOT_W       = $clog2(BUFFER_SLOTS + 1);
   localparam int CMP_W        = (CNT_BITS > CFG_W) ? CNT_BITS : CFG_W;
   localparam int REG_IDX_W    = 2;

   localparam logic [CFG_W-1:0] DEBOUNCE_RESET  = CFG_W'(30);
   localparam logic [CFG_W-1:0] DASH_RESET      = CFG_W'(500);
   localparam logic [CFG_W-1:0] LETTER_GAP_RESET = CFG_W'(2000);
   localparam logic [CFG_W-1:0] TIMEOUT_RESET   = CFG_W'(5000);

   typedef logic [CNT_BITS-1:0] cnt_type;
   typedef logic [CFG_W-1:0]    cfg_word_type;
   typedef logic [SLOT_W-1:0]   slot_type;
   typedef logic [LEN_W-1:0]    len_type;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_DEBOUNCE   = 2'd0,
      REG_DASH       = 2'd1,
      REG_LETTER_GAP = 2'd2,
      REG_TIMEOUT    = 2'd3
   } reg_idx_type;

   typedef struct packed {
      cfg_word_type debounce_ticks;
      cfg_word_type dash_threshold_ticks;
      cfg_word_type letter_gap_ticks;
      cfg_word_type message_timeout_ticks;
   } cfg_type;

   typedef struct packed {
      logic    symbol_valid;
      logic    symbol_is_dash;
      logic    letter_start;
      logic    message_end;
      len_type message_length;
      logic    gap_led;
      logic    key_led;
   } rsp_type;

   function automatic cnt_type sat_inc(input cnt_type v);
      return (v == '1) ? v : v + CNT_BITS'(1);
   endfunction

   function automatic logic cnt_ge_cfg(input cnt_type a, input cfg_word_type b);
      return CMP_W'(a) >= CMP_W'(b);
   endfunction

   function automatic logic cnt_gt_cfg(input cnt_type a, input cfg_word_type b);
      return CMP_W'(a) > CMP_W'(b);
   endfunction

   function automatic len_type len_sat(input slot_type n);
      int unsigned v;
      v = int'(n);
      return (v > LEN_MAX) ? LEN_W'(LEN_MAX) : LEN_W'(v);
   endfunction

endpackage

// File: sv/mktd_csr.sv
// Timing configuration registers with their write port.
module mktd_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [mktd_pkg::REG_IDX_W-1:0]  csr_index,
   input  logic [mktd_pkg::CFG_W-1:0]      csr_data,
   output mktd_pkg::cfg_type               cfg
);

   mktd_pkg::cfg_type cfg_ff;
   mktd_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (mktd_pkg::reg_idx_type'(csr_index))
            mktd_pkg::REG_DEBOUNCE:   cfg_in.debounce_ticks        = csr_data;
            mktd_pkg::REG_DASH:       cfg_in.dash_threshold_ticks  = csr_data;
            mktd_pkg::REG_LETTER_GAP: cfg_in.letter_gap_ticks      = csr_data;
            mktd_pkg::REG_TIMEOUT:    cfg_in.message_timeout_ticks = csr_data;
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks        <= mktd_pkg::DEBOUNCE_RESET;
         cfg_ff.dash_threshold_ticks  <= mktd_pkg::DASH_RESET;
         cfg_ff.letter_gap_ticks      <= mktd_pkg::LETTER_GAP_RESET;
         cfg_ff.message_timeout_ticks <= mktd_pkg::TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: sv/mktd_core.sv
// Key timing state and the per-tick decode of one request.
module mktd_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_accept,
   input  logic              key_level,
   input  mktd_pkg::cfg_type cfg,
   output mktd_pkg::rsp_type rsp
);

   logic               accepted_level_ff, accepted_level_in;
   mktd_pkg::cnt_type  since_edge_ff, since_edge_in;
   mktd_pkg::cnt_type  press_time_ff, press_time_in;
   logic               timing_press_ff, timing_press_in;
   mktd_pkg::slot_type slot_count_ff, slot_count_in;
   mktd_pkg::cnt_type  silence_time_ff, silence_time_in;
   logic               separator_pending_ff, separator_pending_in;
   logic               gap_shown_ff, gap_shown_in;
   logic               key_edge;
   logic               slot_free;

   always_comb begin
      accepted_level_in    = accepted_level_ff;
      timing_press_in      = timing_press_ff;
      slot_count_in        = slot_count_ff;
      separator_pending_in = separator_pending_ff;
      gap_shown_in         = gap_shown_ff;
      rsp                  = '0;

      // advance counters
      since_edge_in   = mktd_pkg::sat_inc(since_edge_ff);
      press_time_in   = timing_press_ff ? mktd_pkg::sat_inc(press_time_ff) : press_time_ff;
      silence_time_in = (slot_count_ff != '0) ? mktd_pkg::sat_inc(silence_time_ff)
                                              : silence_time_ff;

      key_edge  = (key_level != accepted_level_ff) &&
                  mktd_pkg::cnt_ge_cfg(since_edge_in, cfg.debounce_ticks);
      slot_free = slot_count_ff < mktd_pkg::SLOT_W'(mktd_pkg::BUFFER_SLOTS);

      if (key_edge) begin
         accepted_level_in = key_level;
         since_edge_in     = '0;
         if (!key_level) begin
            timing_press_in = 1'b1;
            press_time_in   = '0;
         end else if (timing_press_ff) begin
            if (slot_free) begin
               rsp.symbol_valid     = 1'b1;
               rsp.symbol_is_dash   = mktd_pkg::cnt_ge_cfg(press_time_in,
                                                           cfg.dash_threshold_ticks);
               rsp.letter_start     = separator_pending_ff;
               separator_pending_in = 1'b0;
               slot_count_in        = slot_count_ff + mktd_pkg::SLOT_W'(1);
               silence_time_in      = '0;
               gap_shown_in         = 1'b0;
            end
            timing_press_in = 1'b0;
         end
      end

      rsp.message_length = mktd_pkg::len_sat(slot_count_in);

      if (slot_count_in != '0) begin
         if (!mktd_pkg::cnt_gt_cfg(silence_time_in, cfg.message_timeout_ticks)) begin
            if (mktd_pkg::cnt_gt_cfg(silence_time_in, cfg.letter_gap_ticks)) begin
               gap_shown_in = 1'b1;
               if (!separator_pending_in &&
                   slot_count_in < mktd_pkg::SLOT_W'(mktd_pkg::BUFFER_SLOTS)) begin
                  slot_count_in        = slot_count_in + mktd_pkg::SLOT_W'(1);
                  separator_pending_in = 1'b1;
               end
            end else begin
               gap_shown_in = 1'b0;
            end
            rsp.message_length = mktd_pkg::len_sat(slot_count_in);
         end else begin
            // end the message, drop a trailing separator from the reported length and clear the message state
            rsp.message_end      = 1'b1;
            rsp.message_length   = mktd_pkg::len_sat(slot_count_in -
                                      mktd_pkg::SLOT_W'(separator_pending_in));
            slot_count_in        = '0;
            silence_time_in      = '0;
            separator_pending_in = 1'b0;
            gap_shown_in         = 1'b0;
         end
      end

      rsp.gap_led = gap_shown_in;
      rsp.key_led = timing_press_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accepted_level_ff    <= 1'b1;
         since_edge_ff        <= '1;
         press_time_ff        <= '0;
         timing_press_ff      <= 1'b0;
         slot_count_ff        <= '0;
         silence_time_ff      <= '0;
         separator_pending_ff <= 1'b0;
         gap_shown_ff         <= 1'b0;
      end else if (req_accept) begin
         accepted_level_ff    <= accepted_level_in;
         since_edge_ff        <= since_edge_in;
         press_time_ff        <= press_time_in;
         timing_press_ff      <= timing_press_in;
         slot_count_ff        <= slot_count_in;
         silence_time_ff      <= silence_time_in;
         separator_pending_ff <= separator_pending_in;
         gap_shown_ff         <= gap_shown_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      slot_count_ff <= mktd_pkg::SLOT_W'(mktd_pkg::BUFFER_SLOTS))
      else $error("slot count beyond buffer size");

   assert property (@(posedge clock) disable iff (reset)
      (separator_pending_ff || gap_shown_ff) |-> (slot_count_ff != '0))
      else $error("separator or gap flag set with an empty message");

   assert property (@(posedge clock) disable iff (reset)
      (slot_count_ff == '0) |-> (silence_time_ff == '0))
      else $error("silence counted without a message");

   assert property (@(posedge clock) disable iff (reset)
      (req_accept && rsp.symbol_valid) |=> !timing_press_ff)
      else $error("press timing kept after a symbol");

endmodule

// File: sv/mktd_out_buf.sv
// Result register with a skid stage toward the response channel.
module mktd_out_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_stall,
   input  mktd_pkg::rsp_type in_data,
   output logic              out_valid,
   input  logic              out_stall,
   output mktd_pkg::rsp_type out_data
);

   logic              out_valid_ff, out_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   mktd_pkg::rsp_type out_data_ff, out_data_in;
   mktd_pkg::rsp_type skid_data_ff, skid_data_in;
   logic              in_accept;

   assign in_stall  = skid_valid_ff;
   assign in_accept = in_valid && !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || !out_stall) begin
         if (skid_valid_ff) begin
            out_data_in   = skid_data_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_data_in  = in_data;
            out_valid_in = in_accept;
         end
      end else if (in_accept) begin
         skid_data_in  = in_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid stage holds a request ahead of the result register");

   assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(out_valid_ff && out_stall && in_valid))
      else $error("skid stage filled without a stalled result");

   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_stall && !skid_valid_ff && !in_valid) |=> !out_valid_ff)
      else $error("result register kept a delivered request");

endmodule

// File: sv/morse_key_timing_decoder.sv
// Morse straight-key timing decoder top level.
// The decode is a single registered pass; a result is shown on rsp_valid once registered.
// Throughput: one request per cycle while req_stall is low.
// While a result waits on rsp_stall one more request goes into a skid stage,
// then req_stall holds until the skid stage drains into the result register.
// Reset (synchronous, active high) restores default timing and clears all key state.
module morse_key_timing_decoder (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_key_level,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_symbol_valid,
   output logic                            rsp_symbol_is_dash,
   output logic                            rsp_letter_start,
   output logic                            rsp_message_end,
   output logic [mktd_pkg::LEN_W-1:0]      rsp_message_length,
   output logic                            rsp_gap_led,
   output logic                            rsp_key_led,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [mktd_pkg::REG_IDX_W-1:0]  csr_index,
   input  logic [mktd_pkg::CFG_W-1:0]      csr_data
);

   mktd_pkg::cfg_type cfg;
   mktd_pkg::rsp_type core_rsp;
   mktd_pkg::rsp_type buf_rsp;
   logic              req_accept;

   assign req_accept = req_valid && !req_stall;

   mktd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   mktd_core u_core (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .key_level  (req_key_level),
      .cfg        (cfg),
      .rsp        (core_rsp)
   );

   mktd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_data   (core_rsp),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (buf_rsp)
   );

   assign rsp_symbol_valid   = buf_rsp.symbol_valid;
   assign rsp_symbol_is_dash = buf_rsp.symbol_is_dash;
   assign rsp_letter_start   = buf_rsp.letter_start;
   assign rsp_message_end    = buf_rsp.message_end;
   assign rsp_message_length = buf_rsp.message_length;
   assign rsp_gap_led        = buf_rsp.gap_led;
   assign rsp_key_led        = buf_rsp.key_led;

endmodule
